/* rtl/lidar_nearest_obstacle_steer_defines.svh */
// Assertion macros used by the lidar steering RTL.
`ifndef LIDAR_NEAREST_OBSTACLE_STEER_DEFINES_SVH
`define LIDAR_NEAREST_OBSTACLE_STEER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LNOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LNOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lnos_pkg.sv */
// Types, constants and sine table function for the lidar steering block.
`default_nettype none
package lnos_pkg;

  localparam int IDX_W = 12;
  localparam int RNG_W = 16;

  typedef struct packed {
    logic [RNG_W-1:0] rng;
    logic [IDX_W-1:0] idx;
  } scan_t;

  localparam logic [1:0] REG_CAMERA = 2'd0;
  localparam logic [1:0] REG_FRONT  = 2'd1;
  localparam logic [1:0] REG_BACK   = 2'd2;

  localparam logic CFG_ANGLE_START = 1'b0;
  localparam logic CFG_ANGLE_STEP  = 1'b1;

  localparam logic signed [15:0] ANGLE_START_RST = -16'sd25736;
  localparam logic [12:0]        ANGLE_STEP_RST  = 13'd143;

  localparam int ANG_TWO_PI  = 51472;
  localparam int ANG_HALF_PI = 12868;
  localparam logic signed [26:0] ANG_FRONT = 27'sd12861;

  localparam logic signed [33:0] D_042 = 34'sd7046431;
  localparam logic signed [33:0] D_070 = 34'sd11744051;
  localparam logic signed [33:0] D_055 = 34'sd9227469;
  localparam logic signed [33:0] D_048 = 34'sd8053064;
  localparam logic signed [33:0] D_080 = 34'sd13421773;
  localparam logic signed [33:0] D_020 = 34'sd3355443;
  localparam logic signed [33:0] D_045 = 34'sd7549747;
  localparam logic signed [10:0] G_K1 = 11'sd717;
  localparam logic signed [10:0] G_L1 = 11'sd635;
  localparam logic signed [10:0] G_K2 = 11'sd563;
  localparam logic signed [10:0] G_L2 = 11'sd614;

  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI  = 64'sd6746518853;
  localparam longint Q30_ONE     = 64'sd1073741824;

  // Q1.14 sine of a Q30 phase in [0, 2*pi), Taylor series in Q30.
  function automatic logic signed [15:0] sin_entry(input longint phi_in);
    longint phi;
    longint term;
    longint sum;
    longint s;
    logic   neg;
    phi = phi_in;
    neg = 1'b0;
    if (phi > Q30_PI) begin
      phi = phi - Q30_PI;
      neg = 1'b1;
    end
    if (phi > Q30_HALF_PI) begin
      phi = Q30_PI - phi;
    end
    term = phi;
    sum  = phi;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd6;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd20;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd42;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd72;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd110;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd156;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd210;
    sum  = sum + term;
    term = -(term * phi / Q30_ONE * phi / Q30_ONE) / 64'sd272;
    sum  = sum + term;
    s = sum;
    if (s < 0) begin
      s = 0;
    end
    s = (s + 32768) / 65536;
    if (s > 16384) begin
      s = 16384;
    end
    return neg ? 16'(-s) : 16'(s);
  endfunction

endpackage
`default_nettype wire

/* rtl/lnos_front.sv */
// Per-sample nearest-range tracker; hands finished scans to the queue.
`default_nettype none
module lnos_front import lnos_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [RNG_W-1:0] range_sample_i,
  input  wire logic             last_of_scan_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output scan_t                 q_data_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [RNG_W-1:0] min_q, min_d;
  logic [IDX_W-1:0] min_idx_q, min_idx_d;
  logic             take;
  logic             closer;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign closer     = range_sample_i < min_q;

  always_comb begin
    idx_d          = idx_q;
    min_d          = min_q;
    min_idx_d      = min_idx_q;
    q_push_o       = 1'b0;
    q_data_o.rng   = closer ? range_sample_i : min_q;
    q_data_o.idx   = closer ? idx_q : min_idx_q;
    if (take) begin
      if (last_of_scan_i) begin
        q_push_o  = 1'b1;
        idx_d     = '0;
        min_d     = '1;
        min_idx_d = '0;
      end else begin
        min_d     = q_data_o.rng;
        min_idx_d = q_data_o.idx;
        if (idx_q < IDX_W'(MAX_SAMPLES - 1)) begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      min_q     <= '1;
      min_idx_q <= '0;
    end else begin
      idx_q     <= idx_d;
      min_q     <= min_d;
      min_idx_q <= min_idx_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/lnos_fifo.sv */
// Two-entry queue of finished scans between front and back.
`default_nettype none
`include "lidar_nearest_obstacle_steer_defines.svh"
module lnos_fifo import lnos_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire scan_t wdata_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output scan_t      rdata_o
);

  scan_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `LNOS_ASSERT_IMP(a_no_overflow, full_o, !push_i, "push into full scan queue")
  `LNOS_ASSERT_IMP(a_no_underflow, empty_o, !pop_i, "pop from empty scan queue")
  `LNOS_ASSERT_NXT(a_cnt_moves, push_i != pop_i, cnt_q != $past(cnt_q), "queue count stuck")

endmodule
`default_nettype wire

/* rtl/lnos_div.sv */
// Division by the constant 2*pi (Q3.13) through a reciprocal multiplication.
`default_nettype none
module lnos_div import lnos_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [27:0] num_i,
  output logic             done_o,
  output logic [11:0]      quot_o,
  output logic [15:0]      rem_o
);

  localparam logic [16:0] RECIP = 17'((64'sd1 <<< 32) / ANG_TWO_PI);
  localparam logic [27:0] DVS   = 28'(ANG_TWO_PI);

  logic [27:0] num_q;
  logic [44:0] prod_q;
  logic [12:0] qe_q;
  logic [27:0] rem_q;
  logic [11:0] quot_q;
  logic [15:0] rem_out_q;
  logic [3:0]  stg_q;
  logic        done_q;

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_out_q;

  // estimate is the quotient or one short; the last step corrects it
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      num_q <= num_i;
    end
    if (stg_q[0]) begin
      prod_q <= num_q * RECIP;
    end
    if (stg_q[1]) begin
      qe_q <= prod_q[44:32];
    end
    if (stg_q[2]) begin
      rem_q <= num_q - 28'(qe_q) * DVS;
    end
    if (stg_q[3]) begin
      if (rem_q >= DVS) begin
        quot_q    <= 12'(qe_q + 1'b1);
        rem_out_q <= 16'(rem_q - DVS);
      end else begin
        quot_q    <= qe_q[11:0];
        rem_out_q <= rem_q[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q  <= '0;
      done_q <= 1'b0;
    end else begin
      stg_q  <= {stg_q[2:0], go_i};
      done_q <= stg_q[3];
    end
  end

endmodule
`default_nettype wire

/* rtl/lnos_back.sv */
// End-of-scan sequencer: angle, sine lookups, region test, steering law.
`default_nettype none
module lnos_back import lnos_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [15:0] angle_start_i,
  input  wire logic [12:0]        angle_step_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  input  wire scan_t              q_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              region_o,
  output logic                    avoid_active_o,
  output logic signed [13:0]      steer_rate_o,
  output logic [15:0]             nearest_range_o,
  output logic signed [15:0]      nearest_angle_o
);

  localparam int TW = $clog2(SINE_TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_WRAP, ST_SIDX, ST_CIDX, ST_RDS, ST_RDC,
    ST_Y, ST_CLS, ST_P1, ST_P2, ST_SUM, ST_OUT
  } state_e;

  state_e state_q;

  logic signed [15:0] rom [SINE_TABLE_DEPTH];
  logic signed [15:0] rom_q;
  logic [TW-1:0]      rd_addr;

  logic [15:0]        r_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W+12:0]  prod_q;
  logic signed [26:0] a_q;
  logic signed [26:0] a_sum;
  logic [16:0]        mc_sum;
  logic [15:0]        mc_q;
  logic [TW-1:0]      sidx_q;
  logic [TW-1:0]      cidx_q;
  logic signed [32:0] x_q;
  logic signed [32:0] y_q;
  logic signed [32:0] ax;
  logic signed [32:0] ay;
  logic               front;
  logic signed [33:0] u_q;
  logic signed [33:0] v_q;
  logic signed [10:0] k_q;
  logic signed [10:0] l_q;
  logic signed [44:0] p1_q;
  logic signed [44:0] p2_q;
  logic signed [45:0] acc;
  logic signed [21:0] qv;
  logic [1:0]         region_q;
  logic               hold_q;
  logic signed [13:0] steer_q;
  logic signed [13:0] held_q;
  logic               div_go_q;
  logic [27:0]        div_num_q;
  logic               div_done;
  logic [11:0]        div_quot;
  logic [15:0]        div_rem;

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint PHI = (longint'(k) * Q30_TWO_PI) / longint'(SINE_TABLE_DEPTH);
    assign rom[k] = sin_entry(PHI);
  end

  assign rd_addr = (state_q == ST_RDS) ? sidx_q : cidx_q;

  always_ff @(posedge clk_i) begin
    rom_q <= rom[rd_addr];
  end

  lnos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .num_i  (div_num_q),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign a_sum   = $signed(27'(angle_start_i)) + $signed({1'b0, prod_q})
                   + 27'sd51472;
  assign mc_sum  = {1'b0, div_rem} + 17'(ANG_HALF_PI);
  assign ax      = x_q < 0 ? -x_q : x_q;
  assign ay      = y_q < 0 ? -y_q : y_q;
  assign front   = (a_q > ANG_FRONT) || (a_q < -ANG_FRONT);
  assign acc     = 46'(p1_q) + 46'(p2_q) + 46'sd8388608;
  assign qv      = 22'(acc >>> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_go_q    <= 1'b0;
      out_valid_o <= 1'b0;
      held_q      <= '0;
    end else begin
      div_go_q <= 1'b0;
      if (out_valid_o && !out_stall_i && state_q != ST_OUT) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            r_q     <= q_data_i.rng;
            idx_q   <= q_data_i.idx;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= angle_step_i * idx_q;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          a_q       <= a_sum - 27'sd51472;
          div_num_q <= {1'b0, a_sum};
          div_go_q  <= 1'b1;
          state_q   <= ST_WRAP;
        end
        ST_WRAP: begin
          if (div_done) begin
            mc_q      <= (mc_sum >= 17'(ANG_TWO_PI)) ? 16'(mc_sum - 17'(ANG_TWO_PI))
                                                     : mc_sum[15:0];
            div_num_q <= 28'(div_rem) * 28'(SINE_TABLE_DEPTH);
            div_go_q  <= 1'b1;
            state_q   <= ST_SIDX;
          end
        end
        ST_SIDX: begin
          if (div_done) begin
            sidx_q    <= div_quot[TW-1:0];
            div_num_q <= 28'(mc_q) * 28'(SINE_TABLE_DEPTH);
            div_go_q  <= 1'b1;
            state_q   <= ST_CIDX;
          end
        end
        ST_CIDX: begin
          if (div_done) begin
            cidx_q  <= div_quot[TW-1:0];
            state_q <= ST_RDS;
          end
        end
        ST_RDS: begin
          state_q <= ST_RDC;
        end
        ST_RDC: begin
          x_q     <= $signed({1'b0, r_q}) * rom_q;
          state_q <= ST_Y;
        end
        ST_Y: begin
          y_q     <= $signed({1'b0, r_q}) * rom_q;
          state_q <= ST_CLS;
        end
        ST_CLS: begin
          hold_q   <= 1'b1;
          region_q <= REG_CAMERA;
          if (front && 34'(ax) < D_042 && 34'(ay) < D_070) begin
            region_q <= REG_FRONT;
            hold_q   <= x_q == 0;
            k_q      <= G_K1;
            l_q      <= G_L1;
            u_q      <= x_q > 0 ? 34'(x_q) - D_045 : 34'(x_q) + D_045;
            v_q      <= x_q > 0 ? 34'(y_q) - D_080 : D_080 - 34'(y_q);
          end else if (!front && 34'(ax) < D_055 && 34'(ay) < D_048) begin
            region_q <= REG_BACK;
            hold_q   <= x_q == 0;
            k_q      <= G_K2;
            l_q      <= G_L2;
            u_q      <= 34'(x_q);
            v_q      <= x_q < 0 ? 34'(y_q) - D_020 : D_020 - 34'(y_q);
          end
          state_q <= ST_P1;
        end
        ST_P1: begin
          p1_q    <= 45'(u_q) * 45'(k_q);
          state_q <= ST_P2;
        end
        ST_P2: begin
          p2_q    <= 45'(v_q) * 45'(l_q);
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (hold_q) begin
            steer_q <= held_q;
          end else if (qv > 22'sd8191) begin
            steer_q <= 14'sd8191;
          end else if (qv < -22'sd8192) begin
            steer_q <= 14'sh2000;
          end else begin
            steer_q <= qv[13:0];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o     <= 1'b1;
            region_o        <= region_q;
            avoid_active_o  <= region_q != REG_CAMERA;
            steer_rate_o    <= steer_q;
            held_q          <= steer_q;
            nearest_range_o <= r_q;
            if (a_q > 27'sd32767) begin
              nearest_angle_o <= 16'sh7fff;
            end else if (a_q < -27'sd32768) begin
              nearest_angle_o <= 16'sh8000;
            end else begin
              nearest_angle_o <= a_q[15:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/lidar_nearest_obstacle_steer.sv */
// Lidar nearest-obstacle steering: top level with configuration registers.
// Samples are taken one per cycle; the front stalls only when two scans wait.
// The back end handles one scan at a time and pops the next only when idle;
// three reciprocal divisions by 2*pi dominate its work, which overlaps with
// the samples of the next scan.
// Asynchronous active-low reset clears control state, the scan tracker and the
// held steer; angle_start resets to -25736 and angle_step to 143. No clear pass.
`default_nettype none
module lidar_nearest_obstacle_steer import lnos_pkg::*; #(
  parameter int MAX_SAMPLES      = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] range_sample_i,
  input  wire logic        last_of_scan_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       region_o,
  output logic             avoid_active_o,
  output logic signed [13:0] steer_rate_o,
  output logic [15:0]      nearest_range_o,
  output logic signed [15:0] nearest_angle_o
);

  logic signed [15:0] angle_start_q;
  logic [12:0]        angle_step_q;
  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  scan_t              q_wdata;
  scan_t              q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= ANGLE_START_RST;
      angle_step_q  <= ANGLE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ANGLE_START: angle_start_q <= cfg_wdata_i;
        CFG_ANGLE_STEP:  angle_step_q  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  lnos_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .range_sample_i (range_sample_i),
    .last_of_scan_i (last_of_scan_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  lnos_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  lnos_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .angle_start_i   (angle_start_q),
    .angle_step_i    (angle_step_q),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .q_data_i        (q_rdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .region_o        (region_o),
    .avoid_active_o  (avoid_active_o),
    .steer_rate_o    (steer_rate_o),
    .nearest_range_o (nearest_range_o),
    .nearest_angle_o (nearest_angle_o)
  );

endmodule
`default_nettype wire
